[hdl/tcf_pkg.sv]
// ---------------------------------------------------------------------------
// Touch coordinate filter package
// Shared widths, reset values, register indexes and word types.
// ---------------------------------------------------------------------------
package tcf_pkg;

	localparam int RAW_W       = 12;
	localparam int COORD_W     = 10;
	localparam int HOLD_W      = 2;
	localparam int DEADBAND_W  = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int RAW_PORTS   = 5;
	localparam int SAMPLES_DEF = 5;

	// Magnitude of (median - raw low) * limit and the divider length.
	localparam int NUM_W     = RAW_W + COORD_W;
	localparam int DIV_STEPS = NUM_W;

	localparam logic [RAW_W-1:0]      X_LEFT_RST   = 12'd4000;
	localparam logic [RAW_W-1:0]      X_RIGHT_RST  = 12'd200;
	localparam logic [RAW_W-1:0]      Y_TOP_RST    = 12'd200;
	localparam logic [RAW_W-1:0]      Y_BOTTOM_RST = 12'd3600;
	localparam logic [COORD_W-1:0]    X_LIMIT_RST  = 10'd479;
	localparam logic [COORD_W-1:0]    Y_LIMIT_RST  = 10'd271;
	localparam logic [HOLD_W-1:0]     HOLD_RST     = 2'd2;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_RAW_LEFT      = 3'd0,
		REG_X_RAW_RIGHT     = 3'd1,
		REG_Y_RAW_TOP       = 3'd2,
		REG_Y_RAW_BOTTOM    = 3'd3,
		REG_X_LIMIT         = 3'd4,
		REG_Y_LIMIT         = 3'd5,
		REG_RELEASE_HOLD    = 3'd6,
		REG_JITTER_DEADBAND = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic             touch_detected;
		logic [RAW_W-1:0] raw_x_0;
		logic [RAW_W-1:0] raw_x_1;
		logic [RAW_W-1:0] raw_x_2;
		logic [RAW_W-1:0] raw_x_3;
		logic [RAW_W-1:0] raw_x_4;
		logic [RAW_W-1:0] raw_y_0;
		logic [RAW_W-1:0] raw_y_1;
		logic [RAW_W-1:0] raw_y_2;
		logic [RAW_W-1:0] raw_y_3;
		logic [RAW_W-1:0] raw_y_4;
	} poll_word_t;

	typedef struct packed {
		logic               pressed;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
	} coord_word_t;

endpackage

[hdl/tcf_if.sv]
// ---------------------------------------------------------------------------
// Touch coordinate filter channels
// Valid/ready channels for the poll word and the coordinate word.
// ---------------------------------------------------------------------------
interface tcf_poll_if;
	import tcf_pkg::*;

	logic       valid;
	logic       ready;
	poll_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcf_coord_if;
	import tcf_pkg::*;

	logic        valid;
	logic        ready;
	coord_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/touch_coordinate_filter_unit.sv]
// ---------------------------------------------------------------------------
// Touch coordinate filter unit
// Median, calibration mapping, smoothing and release hold for touch polls.
// ---------------------------------------------------------------------------
// A touched poll is filtered by the single shared unit that serves both axes
// in turn: a rank count over the samples, one per cycle, then a multiply and
// a restoring divider that yields one quotient bit per cycle over 22 steps.
// A released poll skips these and goes straight to the release-hold update.
// A new poll word is taken once the previous one is finished, even while its
// coordinate word still waits to be taken.
module touch_coordinate_filter_unit
	import tcf_pkg::*;
#(
	parameter int SAMPLES_PER_AXIS = SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tcf_poll_if.sink              poll,
	tcf_coord_if.source           coord,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int N      = SAMPLES_PER_AXIS;
	localparam int RANK_W = $clog2(N + 1);
	localparam int CNT_W  = $clog2(DIV_STEPS);
	localparam int PROD_W = RAW_W + COORD_W + 2;
	localparam logic [RANK_W-1:0] MID = RANK_W'(N / 2);
	localparam logic [CNT_W-1:0]  MED_LAST = CNT_W'(N - 1);
	localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(DIV_STEPS - 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MED  = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_MAP  = 7'b0010000,
		S_UPD  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [RAW_W-1:0]      x_left_q, x_right_q, y_top_q, y_bottom_q;
	logic [COORD_W-1:0]    x_limit_q, y_limit_q;
	logic [HOLD_W-1:0]     hold_q;
	logic [DEADBAND_W-1:0] deadband_q;

	logic [COORD_W-1:0] stable_x_q, stable_y_q;
	logic               was_pressed_q;
	logic [HOLD_W-1:0]  release_polls_q;
	logic               pressed_q;

	logic                   touch_q;
	logic                   axis_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [RAW_W-1:0]       w_q [N];
	logic [RAW_W-1:0]       ys_q [N];
	logic [RAW_W-1:0]       med_q;
	logic [NUM_W-1:0]       dvd_q;
	logic [RAW_W-1:0]       rem_q;
	logic [RAW_W-1:0]       den_q;
	logic                   num_neg_q;
	logic                   span_neg_q;
	logic                   span_zero_q;
	logic [COORD_W-1:0]     map_x_q, map_y_q;
	logic                   out_valid_q;
	coord_word_t            out_q;

	logic [RAW_W-1:0]       in_x [RAW_PORTS];
	logic [RAW_W-1:0]       in_y [RAW_PORTS];
	logic [RANK_W-1:0]      lt_cnt, le_cnt;
	logic [RAW_W-1:0]       lo, hi;
	logic [COORD_W-1:0]     limit;
	logic signed [RAW_W:0]  diff_s, span_s;
	logic signed [RAW_W+COORD_W+1:0] prod_s;
	logic [RAW_W+COORD_W+1:0] prod_mag;
	logic [RAW_W:0]         shifted;
	logic [RAW_W+1:0]       trial;
	logic                   qbit;
	logic [COORD_W-1:0]     mapped;
	logic [COORD_W-1:0]     smooth_x, smooth_y;
	logic                   accept;
	logic                   out_free;

	function automatic logic [COORD_W-1:0] smooth(
		input logic [COORD_W-1:0]    old,
		input logic [COORD_W-1:0]    now,
		input logic [DEADBAND_W-1:0] band
	);
		logic [COORD_W-1:0] delta;
		logic [COORD_W+1:0] sum;
		delta = (now > old) ? now - old : old - now;
		sum   = {2'b00, old} + {1'b0, old, 1'b0} + {2'b00, now};
		return (delta > {{(COORD_W-DEADBAND_W){1'b0}}, band}) ? sum[COORD_W+1:2] : old;
	endfunction

	assign accept     = poll.valid & poll.ready;
	assign poll.ready = (state_q == S_IDLE);
	assign out_free   = ~out_valid_q | coord.ready;
	assign coord.valid = out_valid_q;
	assign coord.data  = out_q;

	always_comb begin
		in_x[0] = poll.data.raw_x_0;
		in_x[1] = poll.data.raw_x_1;
		in_x[2] = poll.data.raw_x_2;
		in_x[3] = poll.data.raw_x_3;
		in_x[4] = poll.data.raw_x_4;
		in_y[0] = poll.data.raw_y_0;
		in_y[1] = poll.data.raw_y_1;
		in_y[2] = poll.data.raw_y_2;
		in_y[3] = poll.data.raw_y_3;
		in_y[4] = poll.data.raw_y_4;
	end

	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < N; j++) begin
			lt_cnt = lt_cnt + RANK_W'(w_q[j] < w_q[0]);
			le_cnt = le_cnt + RANK_W'(w_q[j] <= w_q[0]);
		end
	end

	always_comb begin
		lo       = axis_q ? y_top_q : x_left_q;
		hi       = axis_q ? y_bottom_q : x_right_q;
		limit    = axis_q ? y_limit_q : x_limit_q;
		diff_s   = $signed({1'b0, med_q}) - $signed({1'b0, lo});
		span_s   = $signed({1'b0, hi}) - $signed({1'b0, lo});
		prod_s   = PROD_W'(diff_s) * PROD_W'($signed({1'b0, limit}));
		prod_mag = prod_s[RAW_W+COORD_W+1] ? -prod_s : prod_s;
		shifted  = {rem_q, dvd_q[NUM_W-1]};
		trial    = {1'b0, shifted} - {2'b00, den_q};
		qbit     = ~trial[RAW_W+1];
		if (span_zero_q || ((num_neg_q ^ span_neg_q) && (dvd_q != '0))) begin
			mapped = '0;
		end else if (dvd_q > {{(NUM_W-COORD_W){1'b0}}, limit}) begin
			mapped = limit;
		end else begin
			mapped = dvd_q[COORD_W-1:0];
		end
		smooth_x = smooth(stable_x_q, map_x_q, deadband_q);
		smooth_y = smooth(stable_y_q, map_y_q, deadband_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_left_q   <= X_LEFT_RST;
			x_right_q  <= X_RIGHT_RST;
			y_top_q    <= Y_TOP_RST;
			y_bottom_q <= Y_BOTTOM_RST;
			x_limit_q  <= X_LIMIT_RST;
			y_limit_q  <= Y_LIMIT_RST;
			hold_q     <= HOLD_RST;
			deadband_q <= DEADBAND_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_X_RAW_LEFT:      x_left_q   <= cfg_data;
				REG_X_RAW_RIGHT:     x_right_q  <= cfg_data;
				REG_Y_RAW_TOP:       y_top_q    <= cfg_data;
				REG_Y_RAW_BOTTOM:    y_bottom_q <= cfg_data;
				REG_X_LIMIT:         x_limit_q  <= cfg_data[COORD_W-1:0];
				REG_Y_LIMIT:         y_limit_q  <= cfg_data[COORD_W-1:0];
				REG_RELEASE_HOLD:    hold_q     <= cfg_data[HOLD_W-1:0];
				REG_JITTER_DEADBAND: deadband_q <= cfg_data[DEADBAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			stable_x_q      <= '0;
			stable_y_q      <= '0;
			was_pressed_q   <= 1'b0;
			release_polls_q <= '0;
			pressed_q       <= 1'b0;
			out_valid_q     <= 1'b0;
			axis_q          <= 1'b0;
			cnt_q           <= '0;
		end else begin
			if (out_valid_q && coord.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						axis_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= poll.data.touch_detected ? S_MED : S_UPD;
					end
				end
				S_MED: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MED_LAST) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					cnt_q <= '0;
					if (axis_q) begin
						state_q <= S_UPD;
					end else begin
						axis_q  <= 1'b1;
						state_q <= S_MED;
					end
				end
				S_UPD: begin
					if (touch_q) begin
						stable_x_q      <= was_pressed_q ? smooth_x : map_x_q;
						stable_y_q      <= was_pressed_q ? smooth_y : map_y_q;
						was_pressed_q   <= 1'b1;
						release_polls_q <= '0;
						pressed_q       <= 1'b1;
					end else if (was_pressed_q && (release_polls_q < hold_q)) begin
						release_polls_q <= release_polls_q + 1'b1;
						pressed_q       <= 1'b1;
					end else begin
						was_pressed_q <= 1'b0;
						pressed_q     <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					touch_q <= poll.data.touch_detected;
					for (int i = 0; i < N; i++) begin
						w_q[i]  <= in_x[i];
						ys_q[i] <= in_y[i];
					end
				end
			end
			S_MED: begin
				if ((lt_cnt <= MID) && (le_cnt > MID)) begin
					med_q <= w_q[0];
				end
				for (int i = 0; i < N; i++) begin
					w_q[i] <= w_q[(i + 1) % N];
				end
			end
			S_MUL: begin
				dvd_q       <= prod_mag[NUM_W-1:0];
				num_neg_q   <= prod_s[RAW_W+COORD_W+1];
				rem_q       <= '0;
				den_q       <= span_s[RAW_W] ? RAW_W'(-span_s) : span_s[RAW_W-1:0];
				span_neg_q  <= span_s[RAW_W];
				span_zero_q <= (span_s == '0);
			end
			S_DIV: begin
				rem_q <= qbit ? trial[RAW_W-1:0] : shifted[RAW_W-1:0];
				dvd_q <= {dvd_q[NUM_W-2:0], qbit};
			end
			S_MAP: begin
				if (axis_q) begin
					map_y_q <= mapped;
				end else begin
					map_x_q <= mapped;
					for (int i = 0; i < N; i++) begin
						w_q[i] <= ys_q[i];
					end
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q.pressed <= pressed_q;
					out_q.point_x <= stable_x_q;
					out_q.point_y <= stable_y_q;
				end
			end
			default: ;
		endcase
	end

endmodule
